// ===== sv/bid_pkg.sv =====
// Shared types and codes for the bounded integer deque.
package bid_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      is_empty;
        logic [COUNT_W-1:0]        element_count;
        logic signed [VALUE_W-1:0] read_data;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_res_beat;

endpackage

// ===== sv/bid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bid_ctrl.sv =====
// Deque control: front pointer, count, request decode and RAM access sequencing.
module bid_ctrl #(
    parameter int DEPTH = bid_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bid_pkg::FUNC_W-1:0]          i_func,
    input  logic [bid_pkg::VALUE_W-1:0]         i_value,
    input  logic [bid_pkg::POS_W-1:0]           i_pos,
    input  logic                                i_out_ready,
    output bid_pkg::t_res_beat                  o_res,
    output logic                                o_we,
    output logic [$clog2(DEPTH)-1:0]            o_waddr,
    output logic [bid_pkg::VALUE_W-1:0]         o_wdata,
    output logic [$clog2(DEPTH)-1:0]            o_raddr,
    input  logic [bid_pkg::VALUE_W-1:0]         i_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEP_EXT  = (PW+1)'(DEPTH);
    localparam logic [PW-1:0] DEP_M1   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEP_CNT  = CW'(DEPTH);

    bid_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;

    logic            accept;
    logic            full;
    logic            empty;
    logic            pos_bad;
    logic [PW-1:0]   slot_prev;
    logic [PW-1:0]   slot_back;
    logic [PW-1:0]   slot_next;
    logic [PW-1:0]   slot_pos;

    // (base + off) mod DEPTH with base, off < DEPTH
    function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEP_EXT) begin
            sum = sum - DEP_EXT;
        end
        return sum[PW-1:0];
    endfunction

    assign o_ready   = (r_state == bid_pkg::ST_IDLE) && i_out_ready;
    assign accept    = i_valid && o_ready;
    assign full      = (r_count >= DEP_CNT);
    assign empty     = (r_count == '0);
    assign pos_bad   = (32'(i_pos) >= 32'(r_count));
    assign slot_prev = ring_add(r_front, DEP_M1);
    assign slot_back = ring_add(r_front, PW'(r_count));
    assign slot_next = ring_add(r_front, PW'(1));
    assign slot_pos  = ring_add(r_front, PW'(i_pos));

    assign o_raddr = slot_pos;
    assign o_wdata = i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bid_pkg::ST_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_count = r_count;
        o_we    = 1'b0;
        o_waddr = slot_back;
        o_res   = '0;
        case (r_state)
            bid_pkg::ST_IDLE: begin
                if (accept) begin
                    o_res.valid = 1'b1;
                    o_res.result.status = bid_pkg::STATUS_DONE;
                    case (i_func)
                        bid_pkg::FUNC_PUSH_FRONT: begin
                            if (full) begin
                                o_res.result.status = bid_pkg::STATUS_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = slot_prev;
                                n_front = slot_prev;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bid_pkg::FUNC_PUSH_BACK: begin
                            if (full) begin
                                o_res.result.status = bid_pkg::STATUS_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bid_pkg::FUNC_POP_FRONT: begin
                            if (empty) begin
                                o_res.result.status = bid_pkg::STATUS_EMPTY;
                            end else begin
                                n_front = slot_next;
                                n_count = r_count - CW'(1);
                            end
                        end
                        bid_pkg::FUNC_POP_BACK: begin
                            if (empty) begin
                                o_res.result.status = bid_pkg::STATUS_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        bid_pkg::FUNC_READ: begin
                            if (empty) begin
                                o_res.result.status = bid_pkg::STATUS_EMPTY;
                            end else if (pos_bad) begin
                                o_res.result.status = bid_pkg::STATUS_RANGE;
                            end else begin
                                // result follows once the RAM word is back
                                o_res.valid = 1'b0;
                                n_state     = bid_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_res.result.element_count = bid_pkg::COUNT_W'(n_count);
                    o_res.result.is_empty      = (n_count == '0);
                end
            end
            bid_pkg::ST_READ: begin
                o_res.valid                = 1'b1;
                o_res.result.read_data     = i_rdata;
                o_res.result.element_count = bid_pkg::COUNT_W'(r_count);
                o_res.result.is_empty      = empty;
                o_res.result.status        = bid_pkg::STATUS_DONE;
                n_state                    = bid_pkg::ST_IDLE;
            end
            default: begin
                n_state = bid_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bid_out.sv =====
// Output register stage holding one result beat until the sink takes it.
module bid_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bid_pkg::t_res_beat i_res,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output bid_pkg::t_result   o_result
);

    logic             r_valid;
    bid_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_result <= i_res.result;
        end
    end

endmodule

// ===== sv/bounded_int_deque_unit.sv =====
// Top level of the bounded integer deque: ring RAM, control and output stage.
// Double-ended queue of signed 32-bit words held in a DEPTH-entry RAM ring with a
// front pointer and a count. Each input beat carries one request (push front,
// push back, pop front, pop back, read at a position from the front) and gives
// exactly one result beat with read data, count, empty flag and status. Pushes, pops
// and refused requests answer at once; a successful read waits in the read state for
// the registered read data of the ring RAM. A request is taken while no read waits
// and the output register is free or being drained in the same cycle. The RAM needs
// no clearing pass: only entries written by a push are ever read.
module bounded_int_deque_unit #(
    parameter int DEPTH = bid_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // push_value[31:0], position[35:32], zero pad
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data[31:0], element_count[36:32],
                                        // is_empty[37], status[39:38]
);

    localparam int PW = $clog2(DEPTH);

    bid_pkg::t_res_beat               res;
    bid_pkg::t_result                 result;
    logic                             out_ready;
    logic                             we;
    logic [PW-1:0]                    waddr;
    logic [PW-1:0]                    raddr;
    logic [bid_pkg::VALUE_W-1:0]      wdata;
    logic [bid_pkg::VALUE_W-1:0]      rdata;

    bid_ram #(
        .WIDTH (bid_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bid_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_value     (s_axis_tdata[31:0]),
        .i_pos       (s_axis_tdata[35:32]),
        .i_out_ready (out_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    bid_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (res),
        .o_ready  (out_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {result.status, result.is_empty, result.element_count,
                           result.read_data};

endmodule
